/* rtl/ptts_pkg.sv */
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and codes shared by the periodic task tick scheduler and its checker.
// ----------------------------------------------------------------------------
package ptts_pkg;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_CREATE = 3'd1,
		OP_DELETE = 3'd2,
		OP_MODIFY = 3'd3,
		OP_CLEAR  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_END
	} state_t;

	localparam logic KIND_EDIT = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned REF_W    = 8;

endpackage

/* rtl/periodic_task_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Task slot table with create, delete, modify, clear-all and tick requests.
// ----------------------------------------------------------------------------
// Edit requests: the answer is registered and shown next cycle.
// Tick requests: the slots are walked in order through the single read port of
// the period and countdown memories; a due slot waits while a report is held.
// A new request is taken only once the previous one has finished.
// Reset clears the valid marks, the sequencer and the result valid flag; the
// result fields and the period, one-shot and countdown memories are not cleared.
module periodic_task_tick_scheduler #(
	parameter int unsigned SLOT_COUNT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [2:0]                      opcode,
	input  logic [ptts_pkg::REF_W-1:0]      task_id,
	input  logic [ptts_pkg::PERIOD_W-1:0]   period,
	input  logic                            one_shot,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic                            kind,
	output logic [ptts_pkg::REF_W-1:0]      task_ref,
	output logic                            fired,
	output logic                            status,
	output logic                            last
);
	import ptts_pkg::*;

	localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	// slot memories: {one_shot, period} and countdown
	logic [PERIOD_W:0]   per_mem [SLOT_COUNT];
	logic [PERIOD_W-1:0] cnt_mem [SLOT_COUNT];
	logic [PERIOD_W:0]   per_rd_q;
	logic [PERIOD_W-1:0] cnt_rd_q;

	state_t              state_q, state_d;
	logic [SLOT_COUNT-1:0] vld_q, vld_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic                pend_vld_q, pend_vld_d;
	logic [IDX_W-1:0]    pend_ref_q, pend_ref_d;

	logic                out_vld_q;
	logic                kind_q, fired_q, status_q, last_q;
	logic [REF_W-1:0]    ref_q;

	logic                out_free;
	logic                push;
	logic                p_kind, p_fired, p_status, p_last;
	logic [REF_W-1:0]    p_ref;

	logic [IDX_W-1:0]    rd_addr;
	logic                per_we, cnt_we;
	logic [IDX_W-1:0]    per_waddr, cnt_waddr;
	logic [PERIOD_W:0]   per_wdata;
	logic [PERIOD_W-1:0] cnt_wdata;

	logic                in_range, slot_hit;
	logic [IDX_W-1:0]    eslot;
	logic [PERIOD_W-1:0] per_clean;
	logic                accept;

	assign out_free  = !out_vld_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign in_range  = task_id < REF_W'(SLOT_COUNT);
	assign eslot     = task_id[IDX_W-1:0];
	assign slot_hit  = in_range && vld_q[eslot];
	assign per_clean = (period == '0) ? PERIOD_W'(1) : period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		vld_d      = vld_q;
		idx_d      = idx_q;
		pend_vld_d = pend_vld_q;
		pend_ref_d = pend_ref_q;
		req_ready  = 1'b0;
		rd_addr    = '0;
		push       = 1'b0;
		p_kind     = KIND_EDIT;
		p_ref      = '0;
		p_fired    = 1'b0;
		p_status   = STATUS_OK;
		p_last     = 1'b1;
		per_we     = 1'b0;
		per_waddr  = eslot;
		per_wdata  = {one_shot, per_clean};
		cnt_we     = 1'b0;
		cnt_waddr  = eslot;
		cnt_wdata  = '0;

		unique case (state_q)
			ST_IDLE: begin
				req_ready = out_free;
				if (accept) begin
					if (opcode_t'(opcode) == OP_TICK) begin
						state_d    = ST_TICK;
						idx_d      = '0;
						pend_vld_d = 1'b0;
					end else begin
						push     = 1'b1;
						p_ref    = task_id;
						p_status = STATUS_BAD;
						unique case (opcode_t'(opcode))
							OP_CREATE: begin
								if (in_range && !vld_q[eslot]) begin
									vld_d[eslot] = 1'b1;
									per_we       = 1'b1;
									cnt_we       = 1'b1;
									p_status     = STATUS_OK;
								end
							end
							OP_DELETE: begin
								if (slot_hit) begin
									vld_d[eslot] = 1'b0;
									p_status     = STATUS_OK;
								end
							end
							OP_MODIFY: begin
								if (slot_hit) begin
									per_we   = 1'b1;
									p_status = STATUS_OK;
								end
							end
							OP_CLEAR: begin
								vld_d    = '0;
								p_ref    = '0;
								p_status = STATUS_OK;
							end
							default: begin
								// unused codes: answer with a failure, change nothing
							end
						endcase
					end
				end
			end

			ST_TICK: begin
				logic adv;
				adv       = 1'b1;
				rd_addr   = idx_q;
				cnt_waddr = idx_q;
				if (vld_q[idx_q]) begin
					if (cnt_rd_q == '0) begin
						// hold the due slot while an earlier report cannot leave
						if (pend_vld_q && !out_free) begin
							adv = 1'b0;
						end else begin
							if (pend_vld_q) begin
								push    = 1'b1;
								p_kind  = KIND_TICK;
								p_ref   = REF_W'(pend_ref_q);
								p_fired = 1'b1;
								p_last  = 1'b0;
							end
							pend_vld_d = 1'b1;
							pend_ref_d = idx_q;
							if (per_rd_q[PERIOD_W]) begin
								vld_d[idx_q] = 1'b0;
							end else begin
								cnt_we    = 1'b1;
								cnt_wdata = per_rd_q[PERIOD_W-1:0] - PERIOD_W'(1);
							end
						end
					end else begin
						cnt_we    = 1'b1;
						cnt_wdata = cnt_rd_q - PERIOD_W'(1);
					end
				end
				if (adv) begin
					if (idx_q == LAST_IDX) begin
						state_d = ST_END;
						rd_addr = '0;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						rd_addr = idx_q + IDX_W'(1);
					end
				end
			end

			ST_END: begin
				if (out_free) begin
					push    = 1'b1;
					p_kind  = KIND_TICK;
					p_ref   = pend_vld_q ? REF_W'(pend_ref_q) : '0;
					p_fired = pend_vld_q;
					p_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			pend_vld_q <= 1'b0;
			idx_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			vld_q      <= vld_d;
			pend_vld_q <= pend_vld_d;
			idx_q      <= idx_d;
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_ref_q <= pend_ref_d;
		if (push) begin
			kind_q   <= p_kind;
			ref_q    <= p_ref;
			fired_q  <= p_fired;
			status_q <= p_status;
			last_q   <= p_last;
		end
	end

	always_ff @(posedge clk) begin
		if (per_we) begin
			per_mem[per_waddr] <= per_wdata;
		end
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		per_rd_q <= per_mem[rd_addr];
		cnt_rd_q <= cnt_mem[rd_addr];
	end

	assign rsp_valid = out_vld_q;
	assign kind      = kind_q;
	assign task_ref  = ref_q;
	assign fired     = fired_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

/* rtl/ptts_checker.sv */
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks on the result stream of the tick scheduler.
// ----------------------------------------------------------------------------
module ptts_checker #(
	parameter int unsigned SLOT_COUNT = 8
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       kind,
	input logic [ptts_pkg::REF_W-1:0] task_ref,
	input logic                       fired,
	input logic                       status,
	input logic                       last
);
	import ptts_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(task_ref) && $stable(kind)
			&& $stable(last) && $stable(fired) && $stable(status))
		else $error("result changed while stalled");

	a_edit_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_EDIT |-> last && !fired)
		else $error("edit answer not single or marked fired");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_TICK && !fired |-> last && task_ref == '0)
		else $error("empty tick report malformed");

	a_tick_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_TICK |-> status == STATUS_OK)
		else $error("tick report with failure status");

	a_fired_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_TICK && fired |-> task_ref < REF_W'(SLOT_COUNT))
		else $error("fired report names a slot beyond the table");

endmodule

bind periodic_task_tick_scheduler ptts_checker #(.SLOT_COUNT(SLOT_COUNT)) u_ptts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.kind     (kind),
	.task_ref (task_ref),
	.fired    (fired),
	.status   (status),
	.last     (last)
);

/* sim/tb_periodic_task_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Self-checking bench for the task slot table: a directed opening, then random
// request streams with random gaps on both sides and long response stalls.
// Every response is checked field by field against a table kept in step here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_periodic_task_tick_scheduler;
	import ptts_pkg::*;

	localparam int unsigned SLOT_COUNT   = 8;
	localparam int unsigned RANDOM_REQS  = 385;
	localparam int unsigned STALL_CYCLES = 400;
	localparam int unsigned STALL_AT [2] = '{150, 320};
	localparam int unsigned MAX_PRINTS   = 40;

	// opcodes the block does not decode
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef logic [REF_W-1:0]    ref_t;
	typedef logic [PERIOD_W-1:0] per_t;

	typedef struct {
		logic [2:0] op;
		ref_t       id;
		per_t       per;
		logic       once;
	} sched_req_t;

	typedef struct packed {
		logic kind;
		ref_t task_ref;
		logic fired;
		logic status;
		logic last;
	} sched_result_t;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	logic [2:0] opcode;
	ref_t       task_id;
	per_t       period;
	logic       one_shot;
	logic       rsp_valid;
	logic       rsp_ready;
	logic       kind;
	ref_t       task_ref;
	logic       fired;
	logic       status;
	logic       last;

	// table copy kept in step with the block
	logic tbl_valid  [SLOT_COUNT];
	per_t tbl_period [SLOT_COUNT];
	per_t tbl_count  [SLOT_COUNT];
	logic tbl_once   [SLOT_COUNT];

	sched_req_t    pending_reqs[$];
	sched_result_t awaited_answers[$];
	sched_req_t    on_offer;

	int unsigned req_gap;
	bit          req_calm;
	int unsigned rsp_gap;
	bit          rsp_calm;
	int unsigned accepted_reqs;
	int unsigned stall_left;
	int unsigned stalls_done;
	int unsigned mismatches;

	periodic_task_tick_scheduler #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.opcode   (opcode),
		.task_id  (task_id),
		.period   (period),
		.one_shot (one_shot),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.kind     (kind),
		.task_ref (task_ref),
		.fired    (fired),
		.status   (status),
		.last     (last)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTS)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic void queue_req(input logic [2:0] op, input ref_t id, input per_t per,
			input logic once);
		sched_req_t rq;
		rq = '{op, id, per, once};
		pending_reqs.push_back(rq);
	endfunction

	// Update the table for one request and queue the responses it must produce.
	function automatic void apply_request(input sched_req_t rq);
		sched_result_t fire_list[$];
		per_t          per_clean;
		logic          answer;
		logic          in_range;
		per_clean = (rq.per == '0) ? per_t'(1) : rq.per;
		in_range  = rq.id < SLOT_COUNT;
		answer    = STATUS_BAD;
		case (rq.op)
		OP_TICK: begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (tbl_valid[i]) begin
					if (tbl_count[i] == '0) begin
						if (tbl_once[i])
							tbl_valid[i] = 1'b0;
						else
							tbl_count[i] = tbl_period[i] - per_t'(1);
						fire_list.push_back('{KIND_TICK, ref_t'(i), 1'b1, STATUS_OK, 1'b0});
					end else begin
						tbl_count[i] = tbl_count[i] - per_t'(1);
					end
				end
			end
			if (fire_list.size() == 0) begin
				awaited_answers.push_back('{KIND_TICK, ref_t'(0), 1'b0, STATUS_OK, 1'b1});
			end else begin
				fire_list[fire_list.size() - 1].last = 1'b1;
				foreach (fire_list[k])
					awaited_answers.push_back(fire_list[k]);
			end
			return;
		end
		OP_CREATE: begin
			if (in_range && !tbl_valid[rq.id]) begin
				tbl_valid[rq.id]  = 1'b1;
				tbl_period[rq.id] = per_clean;
				tbl_once[rq.id]   = rq.once;
				tbl_count[rq.id]  = '0;
				answer = STATUS_OK;
			end
		end
		OP_DELETE: begin
			if (in_range && tbl_valid[rq.id]) begin
				tbl_valid[rq.id] = 1'b0;
				answer = STATUS_OK;
			end
		end
		OP_MODIFY: begin
			if (in_range && tbl_valid[rq.id]) begin
				tbl_period[rq.id] = per_clean;
				tbl_once[rq.id]   = rq.once;
				answer = STATUS_OK;
			end
		end
		OP_CLEAR: begin
			foreach (tbl_valid[i])
				tbl_valid[i] = 1'b0;
			awaited_answers.push_back('{KIND_EDIT, ref_t'(0), 1'b0, STATUS_OK, 1'b1});
			return;
		end
		default: ;
		endcase
		awaited_answers.push_back('{KIND_EDIT, rq.id, 1'b0, answer, 1'b1});
	endfunction

	function automatic per_t draw_period();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return per_t'($urandom_range(0, 65535));
		2: return '1;
		default: return per_t'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic void queue_random_req();
		int unsigned pick;
		ref_t        id;
		pick = $urandom_range(0, 99);
		// mostly addresses that exist, now and then any id at all
		id = ($urandom_range(0, 4) != 0) ? ref_t'($urandom_range(0, SLOT_COUNT - 1))
			: ref_t'($urandom_range(0, 255));
		if (pick < 40)
			queue_req(OP_TICK, ref_t'($urandom_range(0, 255)), draw_period(),
				logic'($urandom_range(0, 1)));
		else if (pick < 66)
			queue_req(OP_CREATE, id, draw_period(), logic'($urandom_range(0, 3) == 0));
		else if (pick < 78)
			queue_req(OP_DELETE, id, draw_period(), logic'($urandom_range(0, 1)));
		else if (pick < 93)
			queue_req(OP_MODIFY, id, draw_period(), logic'($urandom_range(0, 1)));
		else if (pick < 96)
			queue_req(OP_CLEAR, id, draw_period(), logic'($urandom_range(0, 1)));
		else
			queue_req(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), id, draw_period(),
				logic'($urandom_range(0, 1)));
	endfunction

	// request side: offer the next pending request after a random gap
	always @(posedge clk) begin : drive_requests
		logic offer_next;
		if (arst_n) begin
			offer_next = req_valid;
			if (req_valid && req_ready) begin
				apply_request(on_offer);
				accepted_reqs <= accepted_reqs + 1;
				offer_next = 1'b0;
			end
			if (!offer_next) begin
				if (req_gap != 0) begin
					req_gap--;
				end else if (pending_reqs.size() != 0) begin
					on_offer = pending_reqs.pop_front();
					opcode   <= on_offer.op;
					task_id  <= on_offer.id;
					period   <= on_offer.per;
					one_shot <= on_offer.once;
					offer_next = 1'b1;
					if ($urandom_range(0, 31) == 0)
						req_calm = !req_calm;
					req_gap = req_calm ? 0 : $urandom_range(0, 10);
				end
			end
			req_valid <= offer_next;
		end
	end

	// hold the response side off for a long stretch so the block backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
			end else if (stalls_done < 2 && accepted_reqs >= STALL_AT[stalls_done]) begin
				stall_left  <= STALL_CYCLES;
				stalls_done <= stalls_done + 1;
			end
		end
	end

	// response side: check each accepted response against the oldest awaited one
	always @(posedge clk) begin : collect_answers
		sched_result_t seen;
		sched_result_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				seen = '{kind, task_ref, fired, status, last};
				if (awaited_answers.size() == 0) begin
					report_mismatch($sformatf("unexpected response %p", seen));
				end else begin
					want = awaited_answers.pop_front();
					if (seen.kind !== want.kind || seen.task_ref !== want.task_ref ||
							seen.fired !== want.fired || seen.status !== want.status ||
							seen.last !== want.last)
						report_mismatch($sformatf("got %p, want %p", seen, want));
				end
				if ($urandom_range(0, 31) == 0)
					rsp_calm = !rsp_calm;
				rsp_gap = rsp_calm ? 0 : $urandom_range(0, 10);
			end
			if (stall_left != 0) begin
				rsp_ready <= 1'b0;
			end else if (rsp_gap != 0) begin
				rsp_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		opcode    = OP_TICK;
		task_id   = '0;
		period    = '0;
		one_shot  = 1'b0;
		rsp_ready = 1'b0;
		accepted_reqs = 0;
		stall_left    = 0;
		stalls_done   = 0;
		mismatches    = 0;
		req_gap  = 0;
		rsp_gap  = 0;
		req_calm = 1'b0;
		rsp_calm = 1'b0;
		foreach (tbl_valid[i])
			tbl_valid[i] = 1'b0;

		// tick on an empty table, then fill and probe the edges of each edit
		queue_req(OP_TICK, '0, '0, 1'b0);
		queue_req(OP_CREATE, ref_t'(0), '0, 1'b0);
		queue_req(OP_CREATE, ref_t'(SLOT_COUNT - 1), '1, 1'b1);
		queue_req(OP_CREATE, ref_t'(0), per_t'(5), 1'b0);
		queue_req(OP_CREATE, ref_t'(SLOT_COUNT), per_t'(3), 1'b0);
		queue_req(OP_CREATE, '1, '1, 1'b1);
		queue_req(OP_TICK, '1, '1, 1'b1);
		queue_req(OP_TICK, '0, '0, 1'b0);
		queue_req(OP_MODIFY, ref_t'(0), per_t'(3), 1'b1);
		queue_req(OP_MODIFY, ref_t'(5), per_t'(2), 1'b0);
		queue_req(OP_MODIFY, '1, '0, 1'b1);
		queue_req(OP_DELETE, ref_t'(5), '0, 1'b0);
		queue_req(OP_DELETE, '1, '1, 1'b1);
		queue_req(OP_UNUSED_HI, ref_t'(8'hAA), per_t'(16'h5555), 1'b1);
		queue_req(OP_UNUSED_LO, ref_t'(8'h55), per_t'(16'hAAAA), 1'b0);
		queue_req(OP_TICK, '0, '0, 1'b0);
		queue_req(OP_CLEAR, ref_t'(3), '1, 1'b1);
		// every slot due on the same tick
		for (int i = 0; i < SLOT_COUNT; i++)
			queue_req(OP_CREATE, ref_t'(i), per_t'(1), logic'(i % 2));
		queue_req(OP_TICK, '0, '0, 1'b0);
		queue_req(OP_DELETE, ref_t'(2), '0, 1'b0);

		repeat (RANDOM_REQS)
			queue_random_req();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || awaited_answers.size() != 0);
		repeat (4 * SLOT_COUNT) @(negedge clk);

		if (mismatches == 0 && awaited_answers.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
